// ===== hw/rtl/kdar_pkg.sv =====
package kdar_pkg;

  // Item kinds carried in the kind field of an input word.
  typedef enum logic [1:0] {
    KIND_SCAN  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEBOUNCE       = 2'd0;
  localparam logic [1:0] CFG_FIRST_DELAY    = 2'd1;
  localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd2;

  localparam logic [7:0]  DEBOUNCE_RESET        = 8'd6;
  localparam logic [15:0] FIRST_DELAY_RESET     = 16'd1000;
  localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd200;

  localparam int unsigned KEY_W  = 6;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  typedef struct packed {
    logic [7:0]        stable_count;
    logic              press_armed;
    logic              repeating;
    logic [TIME_W-1:0] last_fire_time;
  } entry_t;

  typedef struct packed {
    logic [7:0]  debounce_count;
    logic [15:0] first_delay_ms;
    logic [15:0] repeat_interval_ms;
  } cfg_t;

endpackage

// ===== hw/rtl/kdar_if.sv =====
interface kdar_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [kdar_pkg::KEY_W-1:0] key_index;
  logic                       raw_level;
  logic                       repeat_enable;

  modport source (output valid, kind, key_index, raw_level, repeat_enable, input ready);
  modport sink   (input valid, kind, key_index, raw_level, repeat_enable, output ready);
endinterface

interface kdar_out_if;
  logic                       valid;
  logic                       ready;
  logic [kdar_pkg::KEY_W-1:0] key_number;
  logic                       fired;

  modport source (output valid, key_number, fired, input ready);
  modport sink   (input valid, key_number, fired, output ready);
endinterface

// ===== hw/rtl/kdar_key_store.sv =====
module kdar_key_store #(
  parameter int unsigned DEPTH = 35,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  kdar_pkg::entry_t wr_data,
  output kdar_pkg::entry_t rd_entry
);
  import kdar_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid;
  entry_t           rd_data;
  logic             rd_valid;
  logic             byp;
  entry_t           byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // Valid bits stand in for clearing the whole store at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      byp      <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
        // A write in the same cycle is not yet in the array, so forward it.
        byp      <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (byp) begin
      rd_entry = byp_data;
    end else if (rd_valid) begin
      rd_entry = rd_data;
    end else begin
      rd_entry = '0;
    end
  end

endmodule

// ===== hw/rtl/kdar_entry_update.sv =====
module kdar_entry_update (
  input  logic [1:0]                  kind,
  input  logic                        in_range,
  input  logic                        raw_level,
  input  logic                        repeat_enable,
  input  logic [kdar_pkg::TIME_W-1:0] now_ms,
  input  kdar_pkg::cfg_t              cfg,
  input  kdar_pkg::entry_t            entry,
  output kdar_pkg::entry_t            entry_next,
  output logic                        wr_en,
  output logic                        fired
);
  import kdar_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic              debounced;
  logic              rep_due;
  logic              first_due;

  assign elapsed   = now_ms - entry.last_fire_time;
  assign debounced = entry.stable_count >= cfg.debounce_count;
  assign rep_due   = elapsed >= TIME_W'(cfg.repeat_interval_ms);
  assign first_due = elapsed >= TIME_W'(cfg.first_delay_ms);
  assign wr_en     = in_range && ((kind == KIND_SCAN) || (kind == KIND_QUERY));

  always_comb begin
    entry_next = entry;
    fired      = 1'b0;
    if (kind == KIND_SCAN) begin
      if (raw_level) begin
        entry_next.stable_count = '0;
        entry_next.press_armed  = 1'b1;
      end else if (!debounced) begin
        entry_next.stable_count = entry.stable_count + 8'd1;
      end
    end else if (kind == KIND_QUERY && in_range && debounced) begin
      priority if (entry.press_armed) begin
        entry_next.press_armed    = 1'b0;
        entry_next.repeating      = 1'b0;
        entry_next.last_fire_time = now_ms;
        fired                     = 1'b1;
      end else if (!repeat_enable) begin
        fired = 1'b0;
      end else if (entry.repeating) begin
        if (rep_due) begin
          entry_next.last_fire_time = now_ms;
          fired                     = 1'b1;
        end
      end else begin
        if (first_due) begin
          entry_next.repeating      = 1'b1;
          entry_next.last_fire_time = now_ms;
          fired                     = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/key_debounce_auto_repeat.sv =====
// Per-key debouncer with auto-repeat. Words enter on key_in (valid/ready):
// a scan word gives one key's raw line level (1 released, 0 pressed), a
// tick word advances the millisecond clock, and a query word asks whether a
// key fires now. Only a query yields a word on fire_out, carrying the key
// number and the fired flag; other kinds are absorbed.
// An accepted query sits in the stage-1 register while its key entry is read,
// then its result is registered onto fire_out. One word is taken every cycle
// unless a query waits on a held result; key state is read at accept, written
// as the word leaves stage 1 and forwarded to a back-to-back word on that key.
// Configuration (debounce count, first delay, repeat interval) must be written
// via cfg_we/cfg_index/cfg_data while the block is idle; it is not checked.
// Reset restores the register defaults (6, 1000, 200), clears the clock and
// marks every key entry as zero through per-key valid bits; no clearing pass
// is needed, and words are accepted in the first cycle after reset.
// When fire_out stalls, the result register holds; a scan or tick word
// still moves through, but a query behind a held result waits, and key_in
// ready drops only then.
module key_debounce_auto_repeat #(
  parameter int unsigned NUM_KEYS = 35
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [kdar_pkg::CFG_W-1:0] cfg_data,
  kdar_in_if.sink                    key_in,
  kdar_out_if.source                 fire_out
);
  import kdar_pkg::*;

  localparam int unsigned AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cfg_t              cfg;
  logic [TIME_W-1:0] now_ms;

  logic              s1_valid;
  logic [1:0]        s1_kind;
  logic [KEY_W-1:0]  s1_key;
  logic [AW-1:0]     s1_addr;
  logic              s1_in_range;
  logic              s1_level;
  logic              s1_rep;
  logic              s1_adv;
  logic              accept;

  entry_t            entry;
  entry_t            entry_next;
  logic              upd_wr;
  logic              upd_fired;
  logic              wr_en;

  logic              out_valid;
  logic [KEY_W-1:0]  key_number;
  logic              fired;

  assign s1_adv = s1_valid && ((s1_kind != KIND_QUERY) || !out_valid || fire_out.ready);
  assign key_in.ready = !s1_valid || s1_adv;
  assign accept = key_in.valid && key_in.ready;
  assign wr_en  = s1_adv && upd_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_count     <= DEBOUNCE_RESET;
      cfg.first_delay_ms     <= FIRST_DELAY_RESET;
      cfg.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:        cfg.debounce_count     <= cfg_data[7:0];
        CFG_FIRST_DELAY:     cfg.first_delay_ms     <= cfg_data;
        CFG_REPEAT_INTERVAL: cfg.repeat_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ticks count at accept; a query in the next cycle sees exactly the
  // ticks that came before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms <= '0;
    end else if (accept && key_in.kind == KIND_TICK) begin
      now_ms <= now_ms + TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= key_in.kind;
      s1_key      <= key_in.key_index;
      s1_addr     <= AW'(key_in.key_index);
      s1_in_range <= 32'(key_in.key_index) < 32'(NUM_KEYS);
      s1_level    <= key_in.raw_level;
      s1_rep      <= key_in.repeat_enable;
    end
  end

  kdar_key_store #(
    .DEPTH (NUM_KEYS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (AW'(key_in.key_index)),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_data  (entry_next),
    .rd_entry (entry)
  );

  kdar_entry_update u_update (
    .kind          (s1_kind),
    .in_range      (s1_in_range),
    .raw_level     (s1_level),
    .repeat_enable (s1_rep),
    .now_ms        (now_ms),
    .cfg           (cfg),
    .entry         (entry),
    .entry_next    (entry_next),
    .wr_en         (upd_wr),
    .fired         (upd_fired)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_kind == KIND_QUERY) begin
      out_valid <= 1'b1;
    end else if (fire_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_kind == KIND_QUERY) begin
      key_number <= s1_key;
      fired      <= upd_fired;
    end
  end

  assign fire_out.valid      = out_valid;
  assign fire_out.key_number = key_number;
  assign fire_out.fired      = fired;

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !key_in.ready)
    else $error("input taken while the stage is stalled");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_kind == KIND_QUERY))
    else $error("result word without a query");

  a_write_on_advance: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_valid && s1_in_range)
    else $error("key store written without a word in range");

  a_non_query_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_kind != KIND_QUERY |-> s1_adv)
    else $error("scan or tick word stalled");

  a_no_fire_out_of_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_in_range |-> !upd_fired)
    else $error("out of range key fired");
`endif

endmodule
